### hdl/bst_pkg.sv
`default_nettype none

package bst_pkg;

  // Operation codes carried by the kind field.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    idx_inc;
    logic    rd_en;
    logic    wr_append;
    logic    wr_shift;
    logic    count_inc;
    logic    count_dec;
    logic    count_clr;
    logic    status_en;
    status_t status_code;
    logic    out_load;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    kind_t in_kind;
    kind_t op;
    logic  scan_end;
    logic  match;
    logic  full;
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/bst_ram.sv
`default_nettype none

module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/bst_ctrl.sv
`default_nettype none

module bst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bst_pkg::dp_stat_t stat,
  output bst_pkg::dp_cmd_t  cmd
);

  import bst_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = ST_DONE;
    in_stall        = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_kind == KIND_CLEAR) begin
            cmd.count_clr   = 1'b1;
            cmd.status_en   = 1'b1;
            cmd.status_code = ST_DONE;
            state_next      = S_FINISH;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          // The value is not held.
          cmd.status_en = 1'b1;
          state_next    = S_FINISH;
          if (stat.op == KIND_INSERT) begin
            if (stat.full) begin
              cmd.status_code = ST_FULL;
            end else begin
              cmd.wr_append   = 1'b1;
              cmd.count_inc   = 1'b1;
              cmd.status_code = ST_DONE;
            end
          end else begin
            cmd.status_code = ST_ABSENT;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          case (stat.op)
            KIND_INSERT: begin
              cmd.status_en   = 1'b1;
              cmd.status_code = ST_PRESENT;
              state_next      = S_FINISH;
            end
            KIND_REMOVE: begin
              cmd.idx_inc = 1'b1;
              state_next  = S_SHIFT_RD;
            end
            default: begin
              cmd.status_en   = 1'b1;
              cmd.status_code = ST_DONE;
              state_next      = S_FINISH;
            end
          endcase
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.scan_end) begin
          cmd.count_dec   = 1'b1;
          cmd.status_en   = 1'b1;
          cmd.status_code = ST_DONE;
          state_next      = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        // Move the entry just read down one place.
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/bst_dp.sv
`default_nettype none

module bst_dp #(
  parameter int CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        kind,
  input  logic signed [31:0] value,
  input  bst_pkg::dp_cmd_t  cmd,
  output bst_pkg::dp_stat_t stat,
  output logic [1:0]        status,
  output logic [5:0]        count
);

  import bst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  kind_t          op;
  logic [31:0]    key;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  idx_m1;
  logic [CW-1:0]  elem_count;
  status_t        result;
  logic [1:0]     out_status;
  logic [5:0]     out_count;

  logic           ram_wr_en;
  logic [IW-1:0]  ram_wr_addr;
  logic [31:0]    ram_wr_data;
  logic [31:0]    ram_rd_data;

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= kind_t'(kind);
      key <= value;
    end
  end

  // Scan index: restarts on each transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
    end else if (cmd.count_clr) begin
      elem_count <= '0;
    end else if (cmd.count_inc) begin
      elem_count <= elem_count + CW'(1);
    end else if (cmd.count_dec) begin
      elem_count <= elem_count - CW'(1);
    end
  end

  // Status of the operation in progress.
  always_ff @(posedge clk) begin
    if (cmd.status_en) begin
      result <= cmd.status_code;
    end
  end

  // Output register, held until the receiver takes it.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= result;
      out_count  <= 6'(elem_count);
    end
  end

  assign status = out_status;
  assign count  = out_count;

  // Write port: append at the end, or shift an entry down one place.
  assign idx_m1      = idx - CW'(1);
  assign ram_wr_en   = cmd.wr_append | cmd.wr_shift;
  assign ram_wr_addr = cmd.wr_shift ? idx_m1[IW-1:0] : elem_count[IW-1:0];
  assign ram_wr_data = cmd.wr_shift ? ram_rd_data : key;

  bst_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx[IW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Status back to the controller.
  always_comb begin
    stat          = '0;
    stat.in_kind  = kind_t'(kind);
    stat.op       = op;
    stat.scan_end = (idx >= elem_count);
    stat.match    = (ram_rd_data == key);
    stat.full     = (elem_count >= CW'(CAPACITY));
  end

endmodule

`default_nettype wire

### hdl/bounded_set_table.sv
// Bounded set table: a set of distinct 32-bit values kept in insertion order.
// Input channel (in_valid/in_stall) carries one operation per transaction:
// kind selects insert, remove, search or clear, and value is the element.
// Output channel (out_valid/out_stall) returns one transaction per operation:
// status (done/found, already present, full, not present) and the new count.
// Entries sit in a single-port-write, registered-read RAM and are scanned one
// at a time; the scan loop through that RAM port sets the latency.
// An insert of a new value, a failed search and any remove pass over all held
// entries; a hit for search or insert stops the scan at the matching entry;
// clear skips the scan. After loading a result the block returns to idle
// before it takes the next operation.
// A finished result waits in an output register; while the receiver stalls,
// that result holds and the next operation may be accepted and worked on, but
// its result is loaded only once the waiting one has been taken.
// Reset empties the set and clears the result valid flag; no clearing pass
// runs, so the block takes operations right after reset.
`default_nettype none

module bounded_set_table #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [5:0]         count
);

  import bst_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .kind   (kind),
    .value  (value),
    .cmd    (cmd),
    .stat   (stat),
    .status (status),
    .count  (count)
  );

endmodule

`default_nettype wire

### hdl/bst_checker.sv
`default_nettype none

module bst_checker #(
  parameter int CAPACITY = 32
) (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire [1:0]         status,
  input wire [5:0]         count
);

  import bst_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count))
    else $error("result changed while stalled");

  // The count never goes beyond the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 63) || (int'(count) <= CAPACITY))
    else $error("count above capacity");

  // A full status is only reported when the set is at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> count == 6'(CAPACITY))
    else $error("full status with room left");

  // An accepted transaction keeps the input stalled while it is worked on.
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  // No result is presented right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind bounded_set_table bst_checker #(.CAPACITY(CAPACITY)) u_bst_checker (.*);

`default_nettype wire

### tb/sv/tb_bounded_set_table.sv
`default_nettype none

module tb_bounded_set_table;
  timeunit 1ns;
  timeprecision 1ps;

  import bst_pkg::*;

  localparam int CAPACITY       = 32;
  localparam int POOL_SIZE      = 48;
  localparam int PHASE_COUNT    = 6;
  localparam int PHASE_ITEMS    = 216;
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;
  localparam int WATCHDOG_LIMIT = 4000;

  // One expected result of the set table.
  typedef struct {
    status_t    status;
    logic [5:0] count;
  } set_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [5:0]         count;

  // Shadow copy of the held elements, oldest insert first.
  logic [31:0] held_values[$];
  // Results still to come back from the block, oldest first.
  set_result_t awaited_results[$];
  logic [31:0] value_pool[POOL_SIZE];

  int error_count  = 0;
  int tx_gap_max   = 10;
  int rx_stall_max = 10;
  int stall_left   = 0;
  int idle_cycles  = 0;
  bit result_taken = 1'b1;

  bounded_set_table #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .count    (count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Position of a value among the held elements, or -1 when absent.
  function automatic int find_value(logic [31:0] v);
    foreach (held_values[i]) begin
      if (held_values[i] == v) return i;
    end
    return -1;
  endfunction

  // Applies one operation to the shadow set and returns the result it gives.
  function automatic set_result_t predict_set_op(kind_t op, logic [31:0] v);
    set_result_t res;
    int          pos;
    res.status = ST_DONE;
    pos = find_value(v);
    case (op)
      KIND_INSERT: begin
        // The duplicate test comes before the full test.
        if (pos >= 0) begin
          res.status = ST_PRESENT;
        end else if (held_values.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          held_values.push_back(v);
        end
      end
      KIND_REMOVE: begin
        if (pos < 0) begin
          res.status = ST_ABSENT;
        end else begin
          held_values.delete(pos);
        end
      end
      KIND_SEARCH: begin
        if (pos < 0) res.status = ST_ABSENT;
      end
      default: begin
        held_values.delete();
      end
    endcase
    res.count = 6'(held_values.size());
    return res;
  endfunction

  // Drives one operation after a random gap and records its expected result.
  task automatic send_op(input kind_t op, input logic [31:0] v);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    kind     = op;
    value    = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(predict_set_op(op, v));
  endtask

  // Stops sending and waits until every result is back, plus a margin.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Empty set, extreme values, every operation and the miss cases.
  task automatic test_extremes();
    tx_gap_max   = 10;
    rx_stall_max = 10;
    send_op(KIND_SEARCH, 32'h0000_0000);
    send_op(KIND_REMOVE, 32'h0000_0005);
    send_op(KIND_INSERT, 32'h8000_0000);
    send_op(KIND_INSERT, 32'h7FFF_FFFF);
    send_op(KIND_INSERT, 32'h0000_0000);
    send_op(KIND_INSERT, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 32'h0000_0001);
    send_op(KIND_INSERT, 32'h8000_0000);
    send_op(KIND_SEARCH, 32'h7FFF_FFFF);
    send_op(KIND_SEARCH, 32'h7FFF_FFFE);
    send_op(KIND_SEARCH, 32'h0000_0001);
    send_op(KIND_REMOVE, 32'h0000_0000);
    send_op(KIND_REMOVE, 32'h8000_0000);
    send_op(KIND_REMOVE, 32'h0000_0001);
    send_op(KIND_REMOVE, 32'h0000_0001);
    send_op(KIND_SEARCH, 32'hFFFF_FFFF);
    send_op(KIND_CLEAR,  32'hFFFF_FFFF);
    send_op(KIND_SEARCH, 32'h7FFF_FFFF);
    send_op(KIND_CLEAR,  32'h0000_0000);
    wait_idle();
  endtask

  // Fills the set to capacity, then overflows, duplicates and removes.
  task automatic test_fill_overflow();
    logic [31:0] v;
    tx_gap_max   = 10;
    rx_stall_max = 10;
    while (held_values.size() < CAPACITY) begin
      do v = $urandom(); while (find_value(v) >= 0);
      send_op(KIND_INSERT, v);
    end
    // A new value is refused when full; a duplicate reports present first.
    do v = $urandom(); while (find_value(v) >= 0);
    send_op(KIND_INSERT, v);
    send_op(KIND_INSERT, held_values[CAPACITY - 1]);
    send_op(KIND_INSERT, held_values[0]);
    send_op(KIND_SEARCH, held_values[CAPACITY - 1]);
    // Removing from the middle must close the gap in order.
    send_op(KIND_REMOVE, held_values[CAPACITY / 2]);
    send_op(KIND_SEARCH, held_values[CAPACITY - 2]);
    send_op(KIND_INSERT, v);
    send_op(KIND_REMOVE, held_values[CAPACITY - 1]);
    send_op(KIND_REMOVE, held_values[0]);
    send_op(KIND_SEARCH, held_values[held_values.size() - 1]);
    send_op(KIND_CLEAR, $urandom());
    wait_idle();
  endtask

  // Random traffic in phases with different operation mixes and idling.
  task automatic test_random_traffic();
    int          ins_pct [PHASE_COUNT] = '{60, 40, 20, 65, 40, 45};
    int          rem_pct [PHASE_COUNT] = '{10, 25, 45, 10, 25, 20};
    int          clr_pct [PHASE_COUNT] = '{1, 2, 2, 1, 3, 8};
    int          tx_max  [PHASE_COUNT] = '{10, 0, 10, 0, 10, 4};
    int          rx_max  [PHASE_COUNT] = '{10, 0, 0, 10, 10, 4};
    int          r;
    kind_t       op;
    logic [31:0] v;
    // A small pool makes duplicates, hits and a full set common.
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'h0000_0001;
    value_pool[2] = 32'h7FFF_FFFF;
    value_pool[3] = 32'h8000_0000;
    value_pool[4] = 32'hFFFF_FFFF;
    for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      tx_gap_max   = tx_max[p];
      rx_stall_max = rx_max[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < clr_pct[p]) begin
          op = KIND_CLEAR;
        end else if (r < clr_pct[p] + ins_pct[p]) begin
          op = KIND_INSERT;
        end else if (r < clr_pct[p] + ins_pct[p] + rem_pct[p]) begin
          op = KIND_REMOVE;
        end else begin
          op = KIND_SEARCH;
        end
        r = $urandom_range(0, 99);
        if (r < 45 && held_values.size() > 0) begin
          v = held_values[$urandom_range(0, held_values.size() - 1)];
        end else if (r < 85) begin
          v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          v = $urandom();
        end
        send_op(op, v);
      end
      wait_idle();
    end
  endtask

  // Receiver: after each taken transaction, stall for a random number of cycles.
  always @(negedge clk) begin
    if (result_taken) begin
      stall_left   = $urandom_range(0, rx_stall_max);
      result_taken = 1'b0;
    end
    if (stall_left > 0) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    set_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      result_taken = 1'b1;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d, count %0d", status, count);
        error_count++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (status !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
          error_count++;
        end
        if (count !== exp_res.count) begin
          $error("count mismatch: expected %0d, actual %0d", exp_res.count, count);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[bounded_set_table] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    kind     = KIND_INSERT;
    value    = '0;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_fill_overflow();
    test_random_traffic();

    if (error_count == 0) begin
      $display("[bounded_set_table] OK");
    end else begin
      $display("[bounded_set_table] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
